// ===== src/sds_pkg.sv =====
// shared types, constants and segment tables for the seven-segment serializer
// used by sds_front, sds_queue, sds_back and seven_segment_char_serializer
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

   // display commands and fixed bytes
   localparam logic [7:0] CMD_DATA   = 8'h44;
   localparam logic [7:0] CMD_AUTO   = 8'h40;
   localparam logic [7:0] GRID_BASE  = 8'hC0;
   localparam logic [7:0] GRID_MID   = 8'hC1;
   localparam logic [7:0] GRID_TOP   = 8'hC2;
   localparam logic [7:0] BLANK_SEG  = 8'h00;
   localparam logic       CTRL_MARK  = 1'b1;

   // symbol kinds on the result channel
   localparam logic [1:0] SYM_START = 2'd0;
   localparam logic [1:0] SYM_DATA  = 2'd1;
   localparam logic [1:0] SYM_ACK   = 2'd2;
   localparam logic [1:0] SYM_STOP  = 2'd3;

   // request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified request, ready for the sequencer
   typedef struct packed {
      logic       mode;
      logic [7:0] addr;
      logic [7:0] seg;
      logic [7:0] ctrl;
   } item_type;

   // digit segment patterns
   function automatic logic [7:0] digit_seg(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h3F;
         4'd1: s = 8'h06;
         4'd2: s = 8'h5B;
         4'd3: s = 8'h4F;
         4'd4: s = 8'h66;
         4'd5: s = 8'h6D;
         4'd6: s = 8'h7D;
         4'd7: s = 8'h07;
         4'd8: s = 8'h7F;
         4'd9: s = 8'h6F;
         default: s = BLANK_SEG;
      endcase
      return s;
   endfunction

   // letter segment patterns, a through y; z has no pattern
   function automatic logic [7:0] letter_seg(input logic [4:0] l);
      logic [7:0] s;
      case (l)
         5'd0:  s = 8'h77;
         5'd1:  s = 8'h7C;
         5'd2:  s = 8'h39;
         5'd3:  s = 8'h5E;
         5'd4:  s = 8'h79;
         5'd5:  s = 8'h71;
         5'd6:  s = 8'h3D;
         5'd7:  s = 8'h76;
         5'd8:  s = 8'h30;
         5'd9:  s = 8'h1E;
         5'd10: s = 8'h40;
         5'd11: s = 8'h38;
         5'd12: s = 8'h40;
         5'd13: s = 8'h54;
         5'd14: s = 8'h3F;
         5'd15: s = 8'h73;
         5'd16: s = 8'h67;
         5'd17: s = 8'h50;
         5'd18: s = 8'h6D;
         5'd19: s = 8'h78;
         5'd20: s = 8'h3E;
         5'd21: s = 8'h1C;
         5'd22: s = 8'h40;
         5'd23: s = 8'h6E;
         5'd24: s = 8'h5B;
         default: s = BLANK_SEG;
      endcase
      return s;
   endfunction

   // ascii character to segment byte, unknown characters blank the digit
   function automatic logic [7:0] char_seg(input logic [7:0] c);
      logic [7:0] s;
      logic [7:0] off;
      s   = BLANK_SEG;
      off = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         off = c - 8'h30;
         s   = digit_seg(off[3:0]);
      end else if (c >= 8'h41 && c <= 8'h59) begin
         off = c - 8'h41;
         s   = letter_seg(off[4:0]);
      end else if (c >= 8'h61 && c <= 8'h79) begin
         off = c - 8'h61;
         s   = letter_seg(off[4:0]);
      end
      return s;
   endfunction

   // digit position to grid address
   function automatic logic [7:0] grid_addr(input logic [1:0] pos);
      logic [7:0] a;
      case (pos)
         2'd2:    a = GRID_MID;
         2'd3:    a = GRID_TOP;
         default: a = GRID_BASE;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== src/sds_front.sv =====
// front end: accepts requests, maps character and position to bytes
// depends on sds_pkg
`timescale 1ns / 1ps
`default_nettype none

module sds_front import sds_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // mode
   input  wire logic [15:0] req_tdata,   // char_code[7:0], position[9:8], zero pad
   input  wire logic [2:0]  brightness,
   input  wire logic        display_on,
   output logic             fe_valid,
   input  wire logic        fe_ready,
   output item_type         fe_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;
   logic     push;

   assign push       = valid_ff && fe_ready;
   assign req_tready = !valid_ff || fe_ready;
   assign take       = req_tvalid && req_tready;

   // classify the incoming transfer
   always_comb begin
      item_in      = item_ff;
      item_in.mode = req_tuser;
      item_in.ctrl = {CTRL_MARK, 3'b000, display_on, brightness};
      if (req_tuser == MODE_CLEAR) begin
         item_in.addr = GRID_BASE;
         item_in.seg  = BLANK_SEG;
      end else begin
         item_in.addr = grid_addr(req_tdata[9:8]);
         item_in.seg  = char_seg(req_tdata[7:0]);
      end
   end

   // holding stage valid
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign fe_valid = valid_ff;
   assign fe_item  = item_ff;

endmodule

`default_nettype wire

// ===== src/sds_queue.sv =====
// short queue of classified requests between front and back end
// depends on sds_pkg
`timescale 1ns / 1ps
`default_nettype none

module sds_queue import sds_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_valid,
   output logic      wr_ready,
   input  item_type  wr_item,
   output logic      rd_valid,
   input  wire logic rd_ready,
   output item_type  rd_item
);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               pop;

   assign wr_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_item  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/sds_back.sv =====
// back end: symbol sequencer with registered result output
// depends on sds_pkg
`timescale 1ns / 1ps
`default_nettype none

module sds_back import sds_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   output logic            q_ready,
   input  item_type        q_item,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // symbol_kind[1:0], bit_value[2], zero pad
   output logic            rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_BIT,
      ST_ACK,
      ST_STOP
   } state_type;

   state_type  state_ff, state_in;
   item_type   cur_ff, cur_in;
   logic [2:0] bit_ff, bit_in;
   logic [2:0] byte_ff, byte_in;
   logic       ovalid_ff, ovalid_in;
   logic [1:0] kind_ff, kind_in;
   logic       bitv_ff, bitv_in;
   logic       last_ff, last_in;

   logic       advance;
   logic [2:0] last_byte;
   logic [2:0] data_end;
   logic [7:0] cur_byte;
   logic       frame_end;

   assign advance = !ovalid_ff || rsp_tready;

   // byte layout of a run: command, address, data bytes, control
   assign last_byte = (cur_ff.mode == MODE_CLEAR) ? 3'd5 : 3'd3;
   assign data_end  = (cur_ff.mode == MODE_CLEAR) ? 3'd4 : 3'd2;
   assign frame_end = (byte_ff == 3'd0) || (byte_ff == data_end) || (byte_ff == last_byte);

   always_comb begin
      if (byte_ff == 3'd0) begin
         cur_byte = (cur_ff.mode == MODE_CLEAR) ? CMD_AUTO : CMD_DATA;
      end else if (byte_ff == 3'd1) begin
         cur_byte = cur_ff.addr;
      end else if (byte_ff == last_byte) begin
         cur_byte = cur_ff.ctrl;
      end else begin
         cur_byte = cur_ff.seg;
      end
   end

   // sequencer next state and next output symbol
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      ovalid_in = ovalid_ff;
      kind_in   = kind_ff;
      bitv_in   = bitv_ff;
      last_in   = last_ff;
      q_ready   = 1'b0;
      if (advance) begin
         ovalid_in = 1'b0;
         bitv_in   = 1'b0;
         last_in   = 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  q_ready  = 1'b1;
                  cur_in   = q_item;
                  byte_in  = 3'd0;
                  state_in = ST_START;
               end
            end
            ST_START: begin
               ovalid_in = 1'b1;
               kind_in   = SYM_START;
               bit_in    = 3'd0;
               state_in  = ST_BIT;
            end
            ST_BIT: begin
               ovalid_in = 1'b1;
               kind_in   = SYM_DATA;
               bitv_in   = cur_byte[bit_ff];
               if (bit_ff == 3'd7) begin
                  state_in = ST_ACK;
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end
            ST_ACK: begin
               ovalid_in = 1'b1;
               kind_in   = SYM_ACK;
               if (frame_end) begin
                  state_in = ST_STOP;
               end else begin
                  byte_in  = byte_ff + 3'd1;
                  bit_in   = 3'd0;
                  state_in = ST_BIT;
               end
            end
            ST_STOP: begin
               ovalid_in = 1'b1;
               kind_in   = SYM_STOP;
               if (byte_ff == last_byte) begin
                  last_in = 1'b1;
                  // start the next queued run without a gap
                  if (q_valid) begin
                     q_ready  = 1'b1;
                     cur_in   = q_item;
                     byte_in  = 3'd0;
                     state_in = ST_START;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  byte_in  = byte_ff + 3'd1;
                  state_in = ST_START;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      cur_ff  <= cur_in;
      bit_ff  <= bit_in;
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      bitv_ff <= bitv_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {5'b00000, bitv_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== src/seven_segment_char_serializer.sv =====
// top level: control registers, front end, request queue and symbol sequencer
// depends on sds_pkg, sds_front, sds_queue, sds_back
`timescale 1ns / 1ps
`default_nettype none

// Turns one request into the symbol run of a two-wire seven-segment display
// write, one symbol per result transfer: 42 symbols for a character write and
// 60 for a clear. The sequencer emits one symbol per cycle while rsp_tready
// allows it; that single sequencer sets the rate. A two-entry queue and a
// holding stage let up to three further requests be taken while a run is going
// out, and a queued request follows the previous stop with no gap. The control
// byte uses brightness and display_on as they stand when the request is
// accepted.

module seven_segment_char_serializer import sds_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // mode
   input  wire logic [15:0] req_tdata,   // char_code[7:0], position[9:8], zero pad
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // symbol_kind[1:0], bit_value[2], zero pad
   output logic             rsp_tlast,   // last
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic REG_BRIGHTNESS = 1'b0;
   localparam logic REG_DISPLAY_ON = 1'b1;

   logic [2:0] brightness_ff, brightness_in;
   logic       display_on_ff, display_on_in;
   logic       csr_write;

   logic       fe_valid;
   logic       fe_ready;
   item_type   fe_item;
   logic       q_valid;
   logic       q_ready;
   item_type   q_item;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      brightness_in = brightness_ff;
      display_on_in = display_on_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_BRIGHTNESS) begin
            brightness_in = csr_pwdata[2:0];
         end else begin
            display_on_in = csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 3'd7;
         display_on_ff <= 1'b1;
      end else begin
         brightness_ff <= brightness_in;
         display_on_ff <= display_on_in;
      end
   end

   // register reads
   assign csr_prdata = (csr_paddr[2] == REG_DISPLAY_ON) ? {31'd0, display_on_ff}
                                                        : {29'd0, brightness_ff};

   sds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .brightness (brightness_ff),
      .display_on (display_on_ff),
      .fe_valid   (fe_valid),
      .fe_ready   (fe_ready),
      .fe_item    (fe_item)
   );

   sds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fe_valid),
      .wr_ready (fe_ready),
      .wr_item  (fe_item),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_item  (q_item)
   );

   sds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // a run always ends on a stop symbol
   a_last_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[1:0] == SYM_STOP)
      else $error("run ended on a symbol other than stop");

   // the data line level is only raised on data bits
   a_bit_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == SYM_DATA)
      else $error("bit value set on a non-data symbol");

   // the symbol after a finished run is a start
   a_start_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=>
         !rsp_tvalid || rsp_tdata[1:0] == SYM_START)
      else $error("new run did not open with a start");
`endif

endmodule

`default_nettype wire
